/* design/crp_pkg.sv */
// Shared types and constants for the concentric ring pattern pixel generator.
// No dependencies.
package crp_pkg;

   localparam int COORD_W    = 10;
   localparam int RADIUS_W   = 9;
   localparam int COUNT_W    = 10;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int ROOT_W     = (SUM_W + 1) / 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = ROOT_W;
   localparam int REM_W      = COUNT_W;
   localparam int DIV_CNT_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET     = 9'd250;
   localparam logic [COUNT_W-1:0]  RING_COUNT_RESET = 10'd10;
   localparam logic [RADIUS_W-1:0] RADIUS_TOP       = 9'd511;

   localparam logic [7:0] PIXEL_WHITE = 8'd255;
   localparam logic [7:0] PIXEL_BLACK = 8'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_COUNT = 2'd1;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       width_clamped;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] root;
   } sqrt_data_type;

   typedef struct packed {
      logic [ROOT_W-1:0] num;
      logic [REM_W-1:0]  rem;
      logic              qbit;
   } div_data_type;

   typedef struct packed {
      logic               busy;
      logic               clamped;
      logic [COUNT_W-1:0] width;
   } ring_cfg_type;

   typedef enum logic [1:0] {
      DIV_IDLE = 2'b01,
      DIV_RUN  = 2'b10
   } div_state_type;

endpackage

/* design/crp_width_div.sv */
// Ring width divider: side / count, restoring, one bit a cycle.
// Uses crp_pkg.
module crp_width_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [crp_pkg::COUNT_W-1:0]   side,
   input  logic [crp_pkg::COUNT_W-1:0]   count,
   output crp_pkg::ring_cfg_type         cfg
);

   crp_pkg::div_state_type state_ff, state_in;
   logic [crp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [crp_pkg::COUNT_W-1:0]   num_ff, num_in;
   logic [crp_pkg::COUNT_W-1:0]   den_ff, den_in;
   logic [crp_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [crp_pkg::COUNT_W-1:0]   quo_ff, quo_in;
   logic [crp_pkg::COUNT_W-1:0]   width_ff, width_in;
   logic                          clamped_ff, clamped_in;
   logic [crp_pkg::COUNT_W:0]     trial;
   logic                          qbit;
   logic [crp_pkg::COUNT_W-1:0]   quo_next;

   always_comb begin
      trial      = {rem_ff, num_ff[crp_pkg::COUNT_W-1]};
      qbit       = (trial >= {1'b0, den_ff});
      quo_next   = {quo_ff[crp_pkg::COUNT_W-2:0], qbit};
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      width_in   = width_ff;
      clamped_in = clamped_ff;
      if (start) begin
         state_in = crp_pkg::DIV_RUN;
         cnt_in   = '0;
         num_in   = side;
         den_in   = count;
         rem_in   = '0;
         quo_in   = '0;
      end else begin
         case (state_ff)
            crp_pkg::DIV_IDLE: begin
            end
            crp_pkg::DIV_RUN: begin
               num_in = {num_ff[crp_pkg::COUNT_W-2:0], 1'b0};
               rem_in = qbit ? crp_pkg::COUNT_W'(trial - {1'b0, den_ff})
                             : crp_pkg::COUNT_W'(trial);
               quo_in = quo_next;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == crp_pkg::DIV_CNT_W'(crp_pkg::COUNT_W - 1)) begin
                  state_in   = crp_pkg::DIV_IDLE;
                  clamped_in = (quo_next == '0);
                  width_in   = (quo_next == '0) ? crp_pkg::COUNT_W'(1) : quo_next;
               end
            end
            default: begin
               state_in = crp_pkg::DIV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crp_pkg::DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      width_ff   <= width_in;
      clamped_ff <= clamped_in;
   end

   assign cfg.busy    = (state_ff != crp_pkg::DIV_IDLE);
   assign cfg.clamped = clamped_ff;
   assign cfg.width   = width_ff;

endmodule

/* design/crp_sqrt_cell.sv */
// One cell of the integer square root chain: resolves one root bit per cell.
// Uses crp_pkg.
module crp_sqrt_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  crp_pkg::sqrt_data_type data_in,
   input  logic                   ready_in,
   output logic                   valid_out,
   output crp_pkg::sqrt_data_type data_out,
   output logic                   ready_out
);

   localparam logic [crp_pkg::SUM_W-1:0] BIT =
      crp_pkg::SUM_W'(1) << (2 * (crp_pkg::SQRT_STEPS - 1 - IDX));

   logic                   valid_ff;
   crp_pkg::sqrt_data_type data_ff, data_in_next;
   logic [crp_pkg::SUM_W:0] trial;

   always_comb begin
      trial = {1'b0, data_in.root} + {1'b0, BIT};
      if ({1'b0, data_in.rem} >= trial) begin
         data_in_next.rem  = crp_pkg::SUM_W'({1'b0, data_in.rem} - trial);
         data_in_next.root = (data_in.root >> 1) + BIT;
      end else begin
         data_in_next.rem  = data_in.rem;
         data_in_next.root = data_in.root >> 1;
      end
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
      if (ready_out) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

/* design/crp_div_cell.sv */
// One cell of the distance / ring width chain: one restoring division step.
// Uses crp_pkg.
module crp_div_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [crp_pkg::COUNT_W-1:0]   width,
   input  logic                          valid_in,
   input  crp_pkg::div_data_type         data_in,
   input  logic                          ready_in,
   output logic                          valid_out,
   output crp_pkg::div_data_type         data_out,
   output logic                          ready_out
);

   logic                      valid_ff;
   crp_pkg::div_data_type     data_ff, data_in_next;
   logic [crp_pkg::REM_W:0]   trial;
   logic                      qbit;

   always_comb begin
      trial             = {data_in.rem, data_in.num[BIT_POS]};
      qbit              = (trial >= {1'b0, width});
      data_in_next.num  = data_in.num;
      data_in_next.qbit = qbit;
      data_in_next.rem  = qbit ? crp_pkg::REM_W'(trial - {1'b0, width})
                               : crp_pkg::REM_W'(trial);
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
      if (ready_out) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

/* design/concentric_ring_pattern_pixel.sv */
// Concentric ring test pattern pixel generator, top level.
// Pipeline from req transfer to rsp valid: 3 front stages, 11 root cells,
// 11 division cells, output register. Throughput: one pixel per cycle while no stall holds it.
// Stages advance independently, so bubbles close up while rsp is stalled.
// Reset (synchronous): valid and configuration registers take their reset values; the
// ring width divider then runs with req_stall high, and again after each csr write.
module concentric_ring_pattern_pixel #(
   parameter int MAX_RADIUS = 511
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  crp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output crp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [crp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [crp_pkg::RADIUS_W-1:0] R_LIMIT =
      (MAX_RADIUS > int'(crp_pkg::RADIUS_TOP)) ? crp_pkg::RADIUS_TOP
                                               : crp_pkg::RADIUS_W'(MAX_RADIUS);

   localparam int NS = crp_pkg::SQRT_STEPS;
   localparam int ND = crp_pkg::DIV_STEPS;

   // configuration
   logic [crp_pkg::RADIUS_W-1:0] radius_ff;
   logic [crp_pkg::COUNT_W-1:0]  ring_count_ff;
   logic                         start_ff;
   logic [crp_pkg::RADIUS_W-1:0] r_sat;
   logic [crp_pkg::COUNT_W-1:0]  side;
   logic [crp_pkg::COUNT_W-1:0]  count;
   crp_pkg::ring_cfg_type        cfg;
   logic                         busy;
   logic                         csr_xfer;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= crp_pkg::RADIUS_RESET;
         ring_count_ff <= crp_pkg::RING_COUNT_RESET;
         start_ff      <= 1'b1;
      end else begin
         start_ff <= csr_xfer;
         if (csr_xfer) begin
            case (csr_index)
               crp_pkg::CSR_RADIUS:     radius_ff <= csr_wdata[crp_pkg::RADIUS_W-1:0];
               crp_pkg::CSR_RING_COUNT: ring_count_ff <= csr_wdata[crp_pkg::COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign r_sat = (radius_ff > R_LIMIT) ? R_LIMIT : radius_ff;
   assign side  = {r_sat, 1'b1};
   assign count = (ring_count_ff == '0) ? crp_pkg::COUNT_W'(1) : ring_count_ff;

   crp_width_div u_width_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .side  (side),
      .count (count),
      .cfg   (cfg)
   );

   assign busy = start_ff || cfg.busy;

   // front stages: |d|, squares, sum
   logic                          va_ff, vb_ff, vc_ff;
   logic [crp_pkg::COORD_W-1:0]   dx_ff, dy_ff;
   logic [crp_pkg::COORD_W-1:0]   dx_in, dy_in;
   logic [crp_pkg::SQ_W-1:0]      dxsq_ff, dysq_ff;
   logic [crp_pkg::SUM_W-1:0]     sum_ff;
   logic                          rdy_a, rdy_b, rdy_c;
   logic [crp_pkg::COORD_W-1:0]   r_ext;
   logic                          req_xfer;

   assign r_ext = crp_pkg::COORD_W'(r_sat);
   assign dx_in = (req_data.row >= r_ext) ? req_data.row - r_ext : r_ext - req_data.row;
   assign dy_in = (req_data.col >= r_ext) ? req_data.col - r_ext : r_ext - req_data.col;

   assign rdy_b     = !vb_ff || rdy_c;
   assign rdy_a     = !va_ff || rdy_b;
   assign req_stall = !rdy_a || busy;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_xfer;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
      end
      if (rdy_a) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (rdy_b) begin
         dxsq_ff <= dx_ff * dx_ff;
         dysq_ff <= dy_ff * dy_ff;
      end
      if (rdy_c) begin
         sum_ff <= {1'b0, dxsq_ff} + {1'b0, dysq_ff};
      end
   end

   // square root chain
   logic                   sq_valid [NS+1];
   crp_pkg::sqrt_data_type sq_data  [NS+1];
   logic                   sq_ready [NS+1];

   assign sq_valid[0]     = vc_ff;
   assign sq_data[0].rem  = sum_ff;
   assign sq_data[0].root = '0;
   assign rdy_c           = !vc_ff || sq_ready[0];

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      crp_sqrt_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (sq_valid[i]),
         .data_in   (sq_data[i]),
         .ready_in  (sq_ready[i+1]),
         .valid_out (sq_valid[i+1]),
         .data_out  (sq_data[i+1]),
         .ready_out (sq_ready[i])
      );
   end

   // division chain, most significant quotient bit first
   logic                  dv_valid [ND+1];
   crp_pkg::div_data_type dv_data  [ND+1];
   logic                  dv_ready [ND+1];

   assign dv_valid[0]     = sq_valid[NS];
   assign dv_data[0].num  = sq_data[NS].root[crp_pkg::ROOT_W-1:0];
   assign dv_data[0].rem  = '0;
   assign dv_data[0].qbit = 1'b0;
   assign sq_ready[NS]    = dv_ready[0];

   for (genvar j = 0; j < ND; j++) begin : g_div
      crp_div_cell #(.BIT_POS(ND - 1 - j)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .width     (cfg.width),
         .valid_in  (dv_valid[j]),
         .data_in   (dv_data[j]),
         .ready_in  (dv_ready[j+1]),
         .valid_out (dv_valid[j+1]),
         .data_out  (dv_data[j+1]),
         .ready_out (dv_ready[j])
      );
   end

   // output register
   logic             rsp_valid_ff;
   crp_pkg::rsp_type rsp_data_ff;
   logic             out_ready;

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign dv_ready[ND] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dv_valid[ND];
      end
      if (out_ready) begin
         rsp_data_ff.pixel         <= dv_data[ND].qbit ? crp_pkg::PIXEL_BLACK
                                                       : crp_pkg::PIXEL_WHITE;
         rsp_data_ff.width_clamped <= cfg.clamped;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_width_nonzero: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (cfg.width != '0))
      else $error("ring width is zero while divider idle");

   a_clamp_width_one: assert property (@(posedge clock) disable iff (reset)
      (!busy && cfg.clamped) |-> (cfg.width == crp_pkg::COUNT_W'(1)))
      else $error("clamped ring width is not one");

   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> req_stall)
      else $error("req taken right after csr write");

   a_pixel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.pixel == crp_pkg::PIXEL_WHITE ||
                        rsp_data_ff.pixel == crp_pkg::PIXEL_BLACK))
      else $error("pixel is neither black nor white");

endmodule
